@@ rtl/core/qwhd_pkg.sv @@
// ----------------------------------------------------------------------------
// qwhd_pkg
// Shared types, constants and the Q1.31 multiply for the quality weighted
// Hamming distance unit.
// ----------------------------------------------------------------------------
package qwhd_pkg;

    localparam int unsigned QUALITY_ENTRIES = 256;
    localparam int unsigned QUAL_W          = 8;
    localparam int unsigned PROB_W          = 32;
    localparam int unsigned COUNT_W         = 15;

    localparam logic [PROB_W-1:0]  Q31_ONE   = 32'h8000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 15'd8;

    typedef enum logic {
        ACT_COMPARE = 1'b0,
        ACT_LOAD    = 1'b1
    } t_action;

    typedef enum logic {
        REG_SCORE_LIMIT   = 1'b0,
        REG_ONE_MINUS_SNP = 1'b1
    } t_reg_idx;

    // one compare step handed to the accumulator
    typedef struct packed {
        logic go;
        logic mismatch;
        logic last;
    } t_step;

    typedef struct packed {
        logic [COUNT_W-1:0] distance;
        logic               over_limit;
        logic [PROB_W-1:0]  map_probability;
    } t_result;

    // (a * b) >> 31, truncated, clamped to one
    function automatic logic [PROB_W-1:0] q31_mul(
        input logic [PROB_W-1:0] a,
        input logic [PROB_W-1:0] b
    );
        logic [2*PROB_W-1:0] p;
        begin
            p = {{PROB_W{1'b0}}, a} * {{PROB_W{1'b0}}, b};
            if (p[2*PROB_W-1:PROB_W-1] > {1'b0, Q31_ONE}) begin
                return Q31_ONE;
            end
            return p[2*PROB_W-2:PROB_W-1];
        end
    endfunction

endpackage

@@ rtl/core/quality_weighted_hamming_distance_unit.sv @@
// ----------------------------------------------------------------------------
// quality_weighted_hamming_distance_unit
// Streams one base per request and scores a read against its reference.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one request per base. A load request
// (action = 1) writes table_value into the quality table at address quality
// and gives no result. A compare request checks text_base against
// pattern_base; a mismatch looks up the quality table. The compare
// request with last = 1 ends the read.
// Output channel (o_valid / i_stall): one request per read with the
// mismatch distance, the over-limit flag and the Q1.31 map probability.
// Throughput: one request per cycle while o_stall is low. A read's result
// passes the input register stage and the result register. The table read
// is issued at acceptance; the count and both running products update in
// the following cycle, each product from a single Q1.31 multiply.
// Configuration: score_limit and one_minus_snp via i_cfg_we / i_cfg_idx /
// i_cfg_data, written while no read is in flight.
// Reset clears the per-read state and the configuration to its defaults;
// the quality table is not cleared and must be loaded before use.
// A stalled result is held in the output register; further bases keep
// flowing until a second last base would need the output register.
// ----------------------------------------------------------------------------
module quality_weighted_hamming_distance_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_text_base,
    input  logic [7:0]  i_pattern_base,
    input  logic [7:0]  i_quality,
    input  logic [31:0] i_table_value,
    input  logic        i_last,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_distance,
    output logic        o_over_limit,
    output logic [31:0] o_map_probability
);

    logic [qwhd_pkg::COUNT_W-1:0] r_score_limit;
    logic [qwhd_pkg::PROB_W-1:0]  r_one_minus_snp;

    logic r_s1_vld;
    logic r_s1_mm;
    logic r_s1_last;

    logic r_out_vld;
    qwhd_pkg::t_result r_out;

    logic                        in_acc;
    logic                        out_free;
    logic                        s1_go;
    logic                        s1_free;
    logic                        is_load;
    logic [qwhd_pkg::PROB_W-1:0] tbl_data;
    qwhd_pkg::t_step             step;
    qwhd_pkg::t_result           res;

    assign is_load  = (i_action == qwhd_pkg::ACT_LOAD);
    assign out_free = !r_out_vld || !i_stall;
    assign s1_go    = r_s1_vld && (!r_s1_last || out_free);
    assign s1_free  = !r_s1_vld || s1_go;
    assign o_stall  = !s1_free;
    assign in_acc   = i_valid && s1_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_limit   <= qwhd_pkg::LIMIT_RESET;
            r_one_minus_snp <= qwhd_pkg::Q31_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qwhd_pkg::REG_SCORE_LIMIT:   r_score_limit   <= i_cfg_data[qwhd_pkg::COUNT_W-1:0];
                qwhd_pkg::REG_ONE_MINUS_SNP: r_one_minus_snp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qwhd_ram #(
        .WIDTH (qwhd_pkg::PROB_W),
        .DEPTH (qwhd_pkg::QUALITY_ENTRIES)
    ) u_qtable (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_load),
        .i_waddr (i_quality),
        .i_wdata (i_table_value),
        .i_re    (in_acc && !is_load),
        .i_raddr (i_quality),
        .o_rdata (tbl_data)
    );

    // input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= in_acc && !is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mm   <= (i_text_base != i_pattern_base);
            r_s1_last <= i_last;
        end
    end

    always_comb begin
        step.go       = s1_go;
        step.mismatch = r_s1_mm;
        step.last     = r_s1_last;
    end

    qwhd_acc u_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_tbl_data      (tbl_data),
        .i_score_limit   (r_score_limit),
        .i_one_minus_snp (r_one_minus_snp),
        .o_result        (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= s1_go && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_distance        = r_out.distance;
    assign o_over_limit      = r_out.over_limit;
    assign o_map_probability = r_out.map_probability;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_over_limit |-> (o_distance == '0) && (o_map_probability == '0))
        else $error("rejected read with nonzero distance or probability");

    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_map_probability <= qwhd_pkg::Q31_ONE))
        else $error("map probability above one");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_s1_last && !out_free |=> r_s1_vld && r_s1_last)
        else $error("last base dropped while output busy");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_last |=> r_out_vld)
        else $error("last base produced no result");

endmodule

@@ rtl/core/qwhd_ram.sv @@
// ----------------------------------------------------------------------------
// qwhd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qwhd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/qwhd_acc.sv @@
// ----------------------------------------------------------------------------
// qwhd_acc
// Per-read accumulator: mismatch count, mismatch and perfect products,
// reject flag. Produces the read result on the last base.
// ----------------------------------------------------------------------------
module qwhd_acc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  qwhd_pkg::t_step                i_step,
    input  logic [qwhd_pkg::PROB_W-1:0]    i_tbl_data,
    input  logic [qwhd_pkg::COUNT_W-1:0]   i_score_limit,
    input  logic [qwhd_pkg::PROB_W-1:0]    i_one_minus_snp,
    output qwhd_pkg::t_result              o_result
);

    logic [qwhd_pkg::COUNT_W-1:0] r_count, n_count;
    logic [qwhd_pkg::PROB_W-1:0]  r_mm_prod, n_mm_prod;
    logic [qwhd_pkg::PROB_W-1:0]  r_pf_prod, n_pf_prod;
    logic                         r_rejected, n_rejected;

    logic                         mm;
    logic [qwhd_pkg::COUNT_W-1:0] cnt_inc;
    logic                         rej_now;

    always_comb begin
        mm      = i_step.mismatch && !r_rejected;
        cnt_inc = (r_count != qwhd_pkg::COUNT_MAX) ? r_count + 1'b1 : r_count;
        rej_now = mm && (cnt_inc > i_score_limit);

        n_count    = mm ? cnt_inc : r_count;
        n_rejected = r_rejected || rej_now;
        n_pf_prod  = qwhd_pkg::q31_mul(r_pf_prod, i_one_minus_snp);
        if (rej_now) begin
            n_mm_prod = '0;
        end else if (mm) begin
            n_mm_prod = qwhd_pkg::q31_mul(r_mm_prod, i_tbl_data);
        end else begin
            n_mm_prod = r_mm_prod;
        end
    end

    always_comb begin
        if (n_rejected) begin
            o_result.distance        = '0;
            o_result.over_limit      = 1'b1;
            o_result.map_probability = '0;
        end else begin
            o_result.distance        = n_count;
            o_result.over_limit      = 1'b0;
            o_result.map_probability = (n_count == '0) ? n_pf_prod : n_mm_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_mm_prod  <= qwhd_pkg::Q31_ONE;
            r_pf_prod  <= qwhd_pkg::Q31_ONE;
            r_rejected <= 1'b0;
        end else if (i_step.go) begin
            if (i_step.last) begin
                r_count    <= '0;
                r_mm_prod  <= qwhd_pkg::Q31_ONE;
                r_pf_prod  <= qwhd_pkg::Q31_ONE;
                r_rejected <= 1'b0;
            end else begin
                r_count    <= n_count;
                r_mm_prod  <= n_mm_prod;
                r_pf_prod  <= n_pf_prod;
                r_rejected <= n_rejected;
            end
        end
    end

endmodule
